// ----- hw/rtl/afc_pkg.sv -----
// Shared types and constants of the ADPCM frame decoder.
package afc_pkg;

    localparam int COUNT_BITS_DEF = 32;
    localparam int CMDQ_DEPTH     = 4;
    localparam int RESQ_DEPTH     = 8;
    localparam int FRAME_BYTES    = 9;
    localparam int PAIR_BYTES     = 18;
    localparam int COEF_SHIFT     = 11;

    localparam logic [1:0] MODE_COEF  = 2'd0;
    localparam logic [1:0] MODE_DATA  = 2'd1;
    localparam logic [1:0] MODE_START = 2'd2;

    // register index as taken from paddr[2]
    localparam logic REG_STEREO = 1'b0;
    localparam logic REG_COUNT  = 1'b1;

    typedef enum logic [1:0] {
        K_COEF  = 2'd0,
        K_START = 2'd1,
        K_DATA  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [4:0]         coef_index;
        logic signed [15:0] coef_value;
        logic [7:0]         data_byte;
    } t_cmd;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               channel;
        logic               last;
    } t_result;

    // up to two results written into the result queue per cycle
    typedef struct packed {
        logic [1:0] cnt;
        t_result    first;
        t_result    second;
    } t_res_wr;

endpackage

// ----- hw/rtl/afc_front.sv -----
// Front end: accepts requests, classifies them and queues commands for the decoder.
module afc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          i_mode,
    input  logic [4:0]          i_coef_index,
    input  logic signed [15:0]  i_coef_value,
    input  logic [7:0]          i_data_byte,
    output logic                o_cmd_valid,
    output afc_pkg::t_cmd       o_cmd,
    input  logic                i_cmd_pop
);

    localparam int AW = $clog2(afc_pkg::CMDQ_DEPTH);

    afc_pkg::t_cmd r_mem [afc_pkg::CMDQ_DEPTH];
    logic [AW-1:0] r_wptr;
    logic [AW-1:0] r_rptr;
    logic [AW:0]   r_count;
    logic [AW:0]   n_count;

    afc_pkg::t_cmd cmd_in;
    logic          keep;
    logic          wr_en;
    logic          rd_en;

    always_comb begin
        cmd_in.coef_index = i_coef_index;
        cmd_in.coef_value = i_coef_value;
        cmd_in.data_byte  = i_data_byte;
        cmd_in.kind       = afc_pkg::K_DATA;
        keep              = 1'b1;
        unique case (i_mode)
            afc_pkg::MODE_COEF:  cmd_in.kind = afc_pkg::K_COEF;
            afc_pkg::MODE_DATA:  cmd_in.kind = afc_pkg::K_DATA;
            afc_pkg::MODE_START: cmd_in.kind = afc_pkg::K_START;
            default:             keep = 1'b0;   // unused mode: dropped
        endcase
    end

    assign full        = (r_count == (AW+1)'(afc_pkg::CMDQ_DEPTH));
    assign wr_en       = push && !full && keep;
    assign rd_en       = i_cmd_pop && o_cmd_valid;
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_mem[r_rptr];

    always_comb begin
        n_count = r_count;
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (!wr_en && rd_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (wr_en) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (rd_en) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/afc_resq.sv -----
// Result queue: up to two writes a cycle, one read.
module afc_resq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  afc_pkg::t_res_wr   i_wr,
    output logic               o_room,
    output logic               empty,
    input  logic               pop,
    output logic signed [15:0] o_sample,
    output logic               o_channel,
    output logic               o_last
);

    localparam int AW = $clog2(afc_pkg::RESQ_DEPTH);

    afc_pkg::t_result r_mem [afc_pkg::RESQ_DEPTH];
    logic [AW-1:0]    r_wptr;
    logic [AW-1:0]    r_rptr;
    logic [AW:0]      r_count;
    logic [AW:0]      n_count;
    logic             rd_en;
    afc_pkg::t_result head;

    assign empty  = (r_count == '0);
    assign rd_en  = pop && !empty;
    assign o_room = ((AW+1)'(afc_pkg::RESQ_DEPTH) - r_count) >= (AW+1)'(2);
    assign head   = r_mem[r_rptr];
    assign o_sample  = head.sample;
    assign o_channel = head.channel;
    assign o_last    = head.last;

    assign n_count = r_count + (AW+1)'(i_wr.cnt) - (AW+1)'(rd_en);

    always_ff @(posedge i_clk) begin
        if (i_wr.cnt != 2'd0) begin
            r_mem[r_wptr] <= i_wr.first;
        end
        if (i_wr.cnt == 2'd2) begin
            r_mem[AW'(r_wptr + 1'b1)] <= i_wr.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            r_wptr  <= r_wptr + AW'(i_wr.cnt);
            if (rd_en) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
    end

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (AW+1)'(afc_pkg::RESQ_DEPTH))
        else $error("result queue overfilled");

endmodule

// ----- hw/rtl/afc_back.sv -----
// Back end: nibble decoder, coefficient table, histories and stereo interleave.
module afc_back #(
    parameter int COUNT_BITS = afc_pkg::COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_valid,
    input  afc_pkg::t_cmd         i_cmd,
    output logic                  o_cmd_pop,
    input  logic                  i_stereo,
    input  logic [COUNT_BITS-1:0] i_limit,
    input  logic                  i_res_room,
    output afc_pkg::t_res_wr      o_res_wr
);

    // coefficient pairs: [15:0] even slot (c0), [31:16] odd slot (c1)
    logic [31:0]        r_coef   [16];
    logic signed [15:0] r_lbuf   [16];
    logic signed [15:0] r_last   [2];
    logic signed [15:0] r_penult [2];
    logic [7:0]         r_hdr    [2];
    logic [4:0]         r_pos;
    logic [COUNT_BITS-1:0] r_emitted;
    logic               r_phase;     // 0: high nibble next, 1: low nibble next

    logic               step;
    logic               is_data;
    logic               done;
    logic [4:0]         pos;
    logic [4:0]         pos_inc;
    logic [4:0]         n_pos;
    logic               is_hdr;
    logic               ch;
    logic               nib_step;
    logic               emit;
    logic               last_flag;
    logic [3:0]         nib;
    logic [7:0]         hdr;
    logic [31:0]        pair;
    logic signed [31:0] prod0;
    logic signed [31:0] prod1;
    logic signed [33:0] n_ext;
    logic signed [33:0] acc;
    logic signed [33:0] s_wide;
    logic signed [15:0] s;
    logic [4:0]         off;
    logic [3:0]         lidx;

    assign step    = i_cmd_valid && i_res_room;
    assign is_data = (i_cmd.kind == afc_pkg::K_DATA);
    assign done    = (r_emitted >= i_limit);

    always_comb begin
        if (i_stereo) begin
            pos = (r_pos >= 5'(afc_pkg::PAIR_BYTES)) ? 5'd0 : r_pos;
        end else begin
            pos = (r_pos >= 5'(afc_pkg::FRAME_BYTES)) ? 5'd0 : r_pos;
        end
        pos_inc = pos + 5'd1;
        if (i_stereo) begin
            n_pos = (pos_inc == 5'(afc_pkg::PAIR_BYTES)) ? 5'd0 : pos_inc;
        end else begin
            n_pos = (pos_inc == 5'(afc_pkg::FRAME_BYTES)) ? 5'd0 : pos_inc;
        end
    end

    assign ch     = i_stereo && (pos >= 5'(afc_pkg::FRAME_BYTES));
    assign is_hdr = (pos == 5'd0) || (i_stereo && pos == 5'(afc_pkg::FRAME_BYTES));

    assign nib_step  = step && is_data && (r_phase || (!done && !is_hdr));
    assign o_cmd_pop = step && (!is_data || r_phase || done || is_hdr);
    assign emit      = nib_step && (r_emitted < i_limit) && (!i_stereo || ch);
    assign last_flag = (COUNT_BITS'(r_emitted + 1'b1) == i_limit);

    // one nibble: s = clamp16((n << e << 11 + c0*last + c1*penult) >>> 11)
    always_comb begin
        nib    = r_phase ? i_cmd.data_byte[3:0] : i_cmd.data_byte[7:4];
        hdr    = r_hdr[ch];
        pair   = r_coef[hdr[3:0]];
        prod0  = $signed(pair[15:0])  * r_last[ch];
        prod1  = $signed(pair[31:16]) * r_penult[ch];
        n_ext  = $signed({{30{nib[3]}}, nib});
        acc    = ((n_ext <<< hdr[7:4]) <<< afc_pkg::COEF_SHIFT)
               + $signed({{2{prod0[31]}}, prod0})
               + $signed({{2{prod1[31]}}, prod1});
        s_wide = acc >>> afc_pkg::COEF_SHIFT;
        if (s_wide > 34'sd32767) begin
            s = 16'sh7FFF;
        end else if (s_wide < -34'sd32768) begin
            s = -16'sh8000;
        end else begin
            s = s_wide[15:0];
        end
    end

    // left buffer slot: two per byte within the frame
    assign off  = ch ? (pos - 5'(afc_pkg::FRAME_BYTES + 1)) : (pos - 5'd1);
    assign lidx = {off[2:0], r_phase};

    always_comb begin
        o_res_wr = '0;
        if (emit) begin
            if (i_stereo) begin
                o_res_wr.cnt    = 2'd2;
                o_res_wr.first  = '{sample: r_lbuf[lidx], channel: 1'b0, last: 1'b0};
                o_res_wr.second = '{sample: s, channel: 1'b1, last: last_flag};
            end else begin
                o_res_wr.cnt   = 2'd1;
                o_res_wr.first = '{sample: s, channel: 1'b0, last: last_flag};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && i_cmd.kind == afc_pkg::K_COEF) begin
            if (i_cmd.coef_index[0]) begin
                r_coef[i_cmd.coef_index[4:1]][31:16] <= i_cmd.coef_value;
            end else begin
                r_coef[i_cmd.coef_index[4:1]][15:0] <= i_cmd.coef_value;
            end
        end
        if (nib_step && i_stereo && !ch) begin
            r_lbuf[lidx] <= s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last    <= '{default: '0};
            r_penult  <= '{default: '0};
            r_hdr     <= '{default: '0};
            r_pos     <= '0;
            r_emitted <= '0;
            r_phase   <= 1'b0;
        end else if (step) begin
            if (i_cmd.kind == afc_pkg::K_START) begin
                r_last    <= '{default: '0};
                r_penult  <= '{default: '0};
                r_hdr     <= '{default: '0};
                r_pos     <= '0;
                r_emitted <= '0;
                r_phase   <= 1'b0;
            end else if (is_data) begin
                if (!r_phase && !done && is_hdr) begin
                    r_hdr[ch] <= i_cmd.data_byte;
                    r_pos     <= n_pos;
                end
                if (nib_step) begin
                    r_penult[ch] <= r_last[ch];
                    r_last[ch]   <= s;
                    r_phase      <= !r_phase;
                    if (r_phase) begin
                        r_pos <= n_pos;
                    end
                end
                if (emit) begin
                    r_emitted <= r_emitted + 1'b1;
                end
            end
        end
    end

    a_phase_holds_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (i_cmd_valid && i_cmd.kind == afc_pkg::K_DATA))
        else $error("low nibble pending without a data byte at queue head");

    a_low_after_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_phase) |-> $past(nib_step))
        else $error("low nibble phase entered without a high nibble decode");

    a_write_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_wr.cnt != 2'd0) |-> i_res_room)
        else $error("result written without queue room");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos < 5'(afc_pkg::PAIR_BYTES))
        else $error("byte position out of range");

endmodule

// ----- hw/rtl/afc_adpcm_frame_decoder.sv -----
// Top level of the 4-bit ADPCM frame decoder: register port, front end, decoder, result queue.
//
// Decodes a byte stream of 9-byte ADPCM frames (header byte: scale exponent in the
// high nibble, coefficient pair index in the low nibble; then 8 bytes of signed
// nibbles, high nibble first) into clamped 16-bit PCM. Requests come through a
// queue-style port (push/full): mode 0 loads one coefficient slot, mode 1 carries a
// stream byte, mode 2 starts a stream (clears histories, headers, byte position and
// the sample counter; coefficients stay), mode 3 is dropped. Results leave through
// empty/pop, oldest first, each with sample, channel and a last flag on the final
// sample once sample_count samples per channel have gone out. In stereo mode the
// stream runs in 18-byte left/right frame pairs and results come out interleaved
// L,R. Every coefficient slot used by a header must be loaded before decoding;
// the table has no reset. The decoder handles one nibble per cycle while a request waits
// and the result queue has room (two 16x16 products, a sum and a clamp, as each nibble
// needs the history left by the previous one) and pops a data byte with its low nibble;
// header, coefficient and start requests pop when handled. It writes at most two results
// a cycle into an 8-deep result queue and waits while fewer than two slots are free; a
// stereo right-frame byte gives four results. A 4-deep request queue separates the input
// port from the decoder, so requests keep being taken while results wait. Registers: 0x0
// stereo_mode (bit 0), 0x4 sample_count (low COUNT_BITS bits used); the user must write
// them only while the block is idle, which the block itself does not enforce.
module afc_adpcm_frame_decoder #(
    parameter int COUNT_BITS = afc_pkg::COUNT_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // request side
    input  logic               push,
    output logic               full,
    input  logic [1:0]         i_mode,
    input  logic [4:0]         i_coef_index,
    input  logic signed [15:0] i_coef_value,
    input  logic [7:0]         i_data_byte,
    // result side
    output logic               empty,
    input  logic               pop,
    output logic signed [15:0] o_sample,
    output logic               o_channel,
    output logic               o_last
);

    logic        r_stereo;
    logic [31:0] r_sample_count;
    logic        cfg_wr;

    logic             cmd_valid;
    afc_pkg::t_cmd    cmd;
    logic             cmd_pop;
    logic             res_room;
    afc_pkg::t_res_wr res_wr;

    // register port: no wait states; index taken from paddr[2]
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[2])
            afc_pkg::REG_STEREO: prdata = {31'd0, r_stereo};
            afc_pkg::REG_COUNT:  prdata = r_sample_count;
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stereo       <= 1'b0;
            r_sample_count <= '0;
        end else if (cfg_wr) begin
            if (paddr[2] == afc_pkg::REG_STEREO) begin
                r_stereo <= pwdata[0];
            end else begin
                r_sample_count <= pwdata;
            end
        end
    end

    // front end: classify and queue requests
    afc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_mode       (i_mode),
        .i_coef_index (i_coef_index),
        .i_coef_value (i_coef_value),
        .i_data_byte  (i_data_byte),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd),
        .i_cmd_pop    (cmd_pop)
    );

    // decoder
    afc_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_stereo    (r_stereo),
        .i_limit     (r_sample_count[COUNT_BITS-1:0]),
        .i_res_room  (res_room),
        .o_res_wr    (res_wr)
    );

    // result queue
    afc_resq u_resq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (res_wr),
        .o_room    (res_room),
        .empty     (empty),
        .pop       (pop),
        .o_sample  (o_sample),
        .o_channel (o_channel),
        .o_last    (o_last)
    );

endmodule
